@@ hw/rtl/aspsp_pkg.sv @@
`timescale 1ns / 1ps

package aspsp_pkg;

    // Width of each number and of the running sum (two's complement range)
    localparam int VALUE_WIDTH = 32;
    localparam int ACC_W       = VALUE_WIDTH - 1;
    localparam int PROD_W      = VALUE_WIDTH + 3;
    localparam int SUM_W       = VALUE_WIDTH;
    localparam int RESULT_W    = 32;

    // Largest magnitude a number may take, at product width
    localparam logic [PROD_W-1:0] VAL_MAX =
        PROD_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
    localparam logic [PROD_W-1:0] DECIMAL_BASE = PROD_W'(10);

    // Token queue and result queue geometry
    localparam int TQ_DEPTH = 4;
    localparam int TQ_AW    = 2;
    localparam int RQ_DEPTH = 2;
    localparam int RQ_AW    = 1;

    // ASCII codes of interest
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_CR    = 8'd13;
    localparam logic [7:0] ASCII_LF    = 8'd10;
    localparam logic [7:0] ASCII_PLUS  = 8'd43;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Class of an incoming byte, decided by the front end
    typedef enum logic [2:0] {
        TOK_DIGIT,
        TOK_PLUS,
        TOK_MINUS,
        TOK_CR,
        TOK_LF,
        TOK_BAD
    } tok_cls_t;

    // Class of the previous accepted byte, kept by the back end
    typedef enum logic [2:0] {
        CLS_START,
        CLS_DIGIT,
        CLS_SIGN,
        CLS_CR,
        CLS_LF
    } prev_cls_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_message;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] sum_value;
        logic                       error_flag;
    } out_item_t;

    // Classified byte passed from front to back through the token queue
    typedef struct packed {
        tok_cls_t   cls;
        logic [3:0] digit;
        logic       last;
        logic       empty_msg;
    } token_t;

    // Finished message waiting for its final term to be added
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [ACC_W-1:0] accum;
        logic             neg;
        logic             err;
    } fin_t;

endpackage

@@ hw/rtl/aspsp_front.sv @@
`timescale 1ns / 1ps

module aspsp_front (
    input  aspsp_pkg::in_item_t item,
    input  logic                push,
    input  logic                tq_full,
    output logic                tq_wr,
    output aspsp_pkg::token_t   token
);
    import aspsp_pkg::*;

    // A transfer happens when the token queue has room
    assign tq_wr = push && !tq_full;

    // Byte classification
    always_comb
    begin
        token.digit     = 4'(item.data_byte - ASCII_ZERO);
        token.last      = item.last_byte;
        token.empty_msg = item.empty_message;
        if (item.data_byte inside {[ASCII_ZERO:ASCII_NINE]})
        begin
            token.cls = TOK_DIGIT;
        end
        else if (item.data_byte == ASCII_PLUS)
        begin
            token.cls = TOK_PLUS;
        end
        else if (item.data_byte == ASCII_MINUS)
        begin
            token.cls = TOK_MINUS;
        end
        else if (item.data_byte == ASCII_CR)
        begin
            token.cls = TOK_CR;
        end
        else if (item.data_byte == ASCII_LF)
        begin
            token.cls = TOK_LF;
        end
        else
        begin
            token.cls = TOK_BAD;
        end
    end

endmodule

@@ hw/rtl/aspsp_token_fifo.sv @@
`timescale 1ns / 1ps

module aspsp_token_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  aspsp_pkg::token_t wr_token,
    output logic              full,
    input  logic              rd,
    output aspsp_pkg::token_t rd_token,
    output logic              valid
);
    import aspsp_pkg::*;

    token_t             mem_reg [TQ_DEPTH];
    logic [TQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [TQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [TQ_AW:0]     cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign full     = (cnt_reg == (TQ_AW+1)'(TQ_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign rd_token = mem_reg[rd_ptr_reg];
    assign do_wr    = wr && !full;
    assign do_rd    = rd && valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_token;
        end
    end

endmodule

@@ hw/rtl/aspsp_back.sv @@
`timescale 1ns / 1ps

module aspsp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tok_valid,
    input  aspsp_pkg::token_t    tok,
    output logic                 tok_rd,
    output logic                 empty,
    input  logic                 pop,
    output aspsp_pkg::out_item_t result
);
    import aspsp_pkg::*;

    // Message state
    logic [ACC_W-1:0]  accum_reg, accum_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              neg_reg, neg_next;
    prev_cls_t         prev_reg, prev_next;
    logic              err_reg, err_next;

    // Byte step results
    logic [ACC_W-1:0]  acc_s;
    logic [SUM_W-1:0]  sum_s;
    logic              neg_s;
    prev_cls_t         prev_s;
    logic              err_s;
    logic [PROD_W-1:0] prod;
    logic [SUM_W:0]    term_sum;
    logic              term_ovf;

    // Finish stage
    fin_t              fin_reg, fin_next;
    logic              fin_valid_reg, fin_valid_next;
    logic              fin_ready, fin_adv, take;
    logic [SUM_W:0]    fin_sum;
    out_item_t         fin_out;

    // Result queue
    out_item_t         rq_mem_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]  rq_wr_ptr_reg, rq_rd_ptr_reg;
    logic [RQ_AW:0]    rq_cnt_reg, rq_cnt_next;
    logic              rq_full, rq_rd;

    assign rq_full   = (rq_cnt_reg == (RQ_AW+1)'(RQ_DEPTH));
    assign empty     = (rq_cnt_reg == '0);
    assign rq_rd     = pop && !empty;
    assign result    = rq_mem_reg[rq_rd_ptr_reg];

    assign fin_adv   = fin_valid_reg && (!rq_full || pop);
    assign fin_ready = !fin_valid_reg || fin_adv;
    assign take      = tok_valid && fin_ready;
    assign tok_rd    = take;

    // Digit step: multiply by ten and add, in product width
    assign prod = PROD_W'(accum_reg) * DECIMAL_BASE + PROD_W'(tok.digit);

    // Sign step: close the current term into the running sum
    assign term_sum = neg_reg ? {sum_reg[SUM_W-1], sum_reg} - {2'b00, accum_reg}
                              : {sum_reg[SUM_W-1], sum_reg} + {2'b00, accum_reg};
    assign term_ovf = term_sum[SUM_W] != term_sum[SUM_W-1];

    // Effect of one byte on the message state
    always_comb
    begin
        acc_s  = accum_reg;
        sum_s  = sum_reg;
        neg_s  = neg_reg;
        prev_s = prev_reg;
        err_s  = err_reg;
        if (!err_reg)
        begin
            case (tok.cls)
                TOK_DIGIT:
                begin
                    if (prev_reg == CLS_CR || prev_reg == CLS_LF || prod > VAL_MAX)
                    begin
                        err_s = 1'b1;
                    end
                    else
                    begin
                        acc_s  = prod[ACC_W-1:0];
                        prev_s = CLS_DIGIT;
                    end
                end
                TOK_PLUS, TOK_MINUS:
                begin
                    if (prev_reg != CLS_DIGIT || term_ovf)
                    begin
                        err_s = 1'b1;
                    end
                    else
                    begin
                        sum_s  = term_sum[SUM_W-1:0];
                        acc_s  = '0;
                        neg_s  = (tok.cls == TOK_MINUS);
                        prev_s = CLS_SIGN;
                    end
                end
                TOK_CR:
                begin
                    if (prev_reg != CLS_DIGIT)
                    begin
                        err_s = 1'b1;
                    end
                    else
                    begin
                        prev_s = CLS_CR;
                    end
                end
                TOK_LF:
                begin
                    if (prev_reg != CLS_CR)
                    begin
                        err_s = 1'b1;
                    end
                    else
                    begin
                        prev_s = CLS_LF;
                    end
                end
                default:
                begin
                    err_s = 1'b1;
                end
            endcase
        end
    end

    // State update and hand-off to the finish stage
    always_comb
    begin
        accum_next     = accum_reg;
        sum_next       = sum_reg;
        neg_next       = neg_reg;
        prev_next      = prev_reg;
        err_next       = err_reg;
        fin_next       = fin_reg;
        fin_valid_next = fin_valid_reg;
        if (fin_ready)
        begin
            fin_valid_next = 1'b0;
        end
        if (take)
        begin
            if (tok.empty_msg || tok.last)
            begin
                fin_valid_next = 1'b1;
                fin_next.sum   = sum_s;
                fin_next.accum = acc_s;
                fin_next.neg   = neg_s;
                fin_next.err   = tok.empty_msg || err_s ||
                                 (prev_s != CLS_DIGIT && prev_s != CLS_LF);
                accum_next     = '0;
                sum_next       = '0;
                neg_next       = 1'b0;
                prev_next      = CLS_START;
                err_next       = 1'b0;
            end
            else
            begin
                accum_next = acc_s;
                sum_next   = sum_s;
                neg_next   = neg_s;
                prev_next  = prev_s;
                err_next   = err_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= '0;
            sum_reg       <= '0;
            neg_reg       <= 1'b0;
            prev_reg      <= CLS_START;
            err_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg     <= accum_next;
            sum_reg       <= sum_next;
            neg_reg       <= neg_next;
            prev_reg      <= prev_next;
            err_reg       <= err_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    // Finish stage: add the last term and check the final range
    assign fin_sum = fin_reg.neg
                   ? {fin_reg.sum[SUM_W-1], fin_reg.sum} - {2'b00, fin_reg.accum}
                   : {fin_reg.sum[SUM_W-1], fin_reg.sum} + {2'b00, fin_reg.accum};

    always_comb
    begin
        fin_out.error_flag = fin_reg.err || (fin_sum[SUM_W] != fin_sum[SUM_W-1]);
        fin_out.sum_value  = fin_out.error_flag
                           ? '0
                           : RESULT_W'(signed'(fin_sum[SUM_W-1:0]));
    end

    // Result queue: two entries so a waiting result never blocks the next
    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        if (fin_adv && !rq_rd)
        begin
            rq_cnt_next = rq_cnt_reg + 1'b1;
        end
        else if (!fin_adv && rq_rd)
        begin
            rq_cnt_next = rq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_cnt_reg    <= '0;
        end
        else
        begin
            if (fin_adv)
            begin
                rq_wr_ptr_reg <= rq_wr_ptr_reg + 1'b1;
            end
            if (rq_rd)
            begin
                rq_rd_ptr_reg <= rq_rd_ptr_reg + 1'b1;
            end
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_adv)
        begin
            rq_mem_reg[rq_wr_ptr_reg] <= fin_out;
        end
    end

endmodule

@@ hw/rtl/ascii_plus_minus_sum_parser_top.sv @@
`timescale 1ns / 1ps

// Evaluates a byte stream such as "12+7-30", optionally closed by CR LF, one
// byte per transfer, and queues one result (signed 32-bit sum or error flag)
// per message, raised on the byte marked last or on an empty-message marker.
// Sustained rate is one byte per clock while results are popped: the front
// end classifies a byte as it is pushed, a four-entry token queue decouples
// it from the back end, which, unless its finish stage is held, applies one
// byte a cycle (a multiply-by-ten-and-add or a term addition) and then adds
// the final term in a separate finish stage, whose result goes into a
// two-entry result queue that lets bytes keep flowing while results wait
// to be popped. Numbers above 2^31-1 and sums outside the signed 32-bit
// range give an error, and an error result always carries a zero sum.
module ascii_plus_minus_sum_parser_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  aspsp_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output aspsp_pkg::out_item_t result
);
    import aspsp_pkg::*;

    token_t token_in, token_out;
    logic   tq_wr, tq_rd, tq_valid;

    aspsp_front u_front (
        .item    (item),
        .push    (push),
        .tq_full (full),
        .tq_wr   (tq_wr),
        .token   (token_in)
    );

    aspsp_token_fifo u_token_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tq_wr),
        .wr_token (token_in),
        .full     (full),
        .rd       (tq_rd),
        .rd_token (token_out),
        .valid    (tq_valid)
    );

    aspsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tq_valid),
        .tok       (token_out),
        .tok_rd    (tq_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
